// File: src/slist_pkg.sv
// ----------------------------------------------------------------------------
// slist_pkg
// Shared constants, codes and control types for the sequential list engine.
// ----------------------------------------------------------------------------
package slist_pkg;

  localparam int CAPACITY = 64;

  localparam int KEY_W   = 32;
  localparam int POS_W   = 7;
  localparam int IDX_W   = 7;
  localparam int COUT_W  = 7;
  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  // command kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // read address select
  localparam logic [1:0] RD_PTR = 2'd0;
  localparam logic [1:0] RD_DEC = 2'd1;
  localparam logic [1:0] RD_INC = 2'd2;

  // result index select
  localparam logic [1:0] IDX_NONE = 2'd0;
  localparam logic [1:0] IDX_POS  = 2'd1;
  localparam logic [1:0] IDX_PTR  = 2'd2;
  localparam logic [1:0] IDX_HIT  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       ptr_to_count;
    logic       ptr_to_zero;
    logic       ptr_inc;
    logic       ptr_dec;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic       wr_key;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       hit_save;
    logic       res_set;
    logic       res_ok;
    logic [1:0] res_idx;
  } slist_cmd_t;

  typedef struct packed {
    logic ins_ok;
    logic cnt_gt_inpos;
    logic cnt_zero;
    logic ptr_dec_gt_pos;
    logic match;
    logic scan_more;
    logic dn_more;
  } slist_status_t;

endpackage

// File: src/slist_ram.sv
// ----------------------------------------------------------------------------
// slist_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module slist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/slist_datapath.sv
// ----------------------------------------------------------------------------
// slist_datapath
// Entry store, count, scan pointer, compares and result registers.
// ----------------------------------------------------------------------------
module slist_datapath
  import slist_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  slist_cmd_t               cmd,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic        [POS_W-1:0]  in_position,
  output slist_status_t            status,
  output logic                     out_ok,
  output logic signed [IDX_W-1:0]  out_index,
  output logic        [COUT_W-1:0] out_count
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  hit_r;
  logic [KEY_W-1:0]  key_r;
  logic [POS_W-1:0]  pos_r;
  logic              ok_r;
  logic [IDX_W-1:0]  index_r;

  logic [CNT_W-1:0]  ptr_m1, ptr_p1;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [KEY_W-1:0]  wdata, rdata;
  logic [IDX_W-1:0]  res_index;

  assign ptr_m1 = ptr_r - CNT_W'(1);
  assign ptr_p1 = ptr_r + CNT_W'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PTR:  raddr = ptr_r[ADDR_W-1:0];
      RD_DEC:  raddr = ptr_m1[ADDR_W-1:0];
      RD_INC:  raddr = ptr_p1[ADDR_W-1:0];
      default: raddr = ptr_r[ADDR_W-1:0];
    endcase
  end

  assign waddr = cmd.wr_key ? ADDR_W'(pos_r) : ptr_r[ADDR_W-1:0];
  assign wdata = cmd.wr_key ? key_r : rdata;

  slist_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_slist_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status toward the controller
  assign status.ins_ok = (count_r < CNT_W'(CAPACITY)) &&
                         (CMP_W'(in_position) <= CMP_W'(count_r));
  assign status.cnt_gt_inpos   = CMP_W'(count_r) > CMP_W'(in_position);
  assign status.cnt_zero       = (count_r == '0);
  assign status.ptr_dec_gt_pos = (CMP_W'(ptr_r) - CMP_W'(1)) > CMP_W'(pos_r);
  assign status.match          = (rdata == key_r);
  assign status.scan_more      = (CMP_W'(ptr_r) + CMP_W'(1)) < CMP_W'(count_r);
  assign status.dn_more        = (CMP_W'(ptr_r) + CMP_W'(2)) < CMP_W'(count_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_to_count) begin
      ptr_nxt = count_r;
    end else if (cmd.ptr_to_zero) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_p1;
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_m1;
    end
  end

  always_comb begin
    unique case (cmd.res_idx)
      IDX_NONE: res_index = '1;
      IDX_POS:  res_index = IDX_W'(pos_r);
      IDX_PTR:  res_index = IDX_W'(ptr_r);
      IDX_HIT:  res_index = IDX_W'(hit_r);
      default:  res_index = '1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      key_r <= in_key;
      pos_r <= in_position;
    end
    if (cmd.hit_save) begin
      hit_r <= ptr_r;
    end
    if (cmd.res_set) begin
      ok_r    <= cmd.res_ok;
      index_r <= res_index;
    end
  end

  assign out_ok    = ok_r;
  assign out_index = index_r;
  // count register already holds the post-operation value while the result shows
  assign out_count = COUT_W'(count_r);

endmodule

// File: src/slist_ctrl.sv
// ----------------------------------------------------------------------------
// slist_ctrl
// Command sequencer: scans, shifts and result strobe for each item.
// ----------------------------------------------------------------------------
module slist_ctrl
  import slist_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_kind,
  input  slist_status_t status,
  output slist_cmd_t    cmd,
  output logic          busy,
  output logic          out_valid
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_WR  = 3'd2;
  localparam logic [2:0] S_WR_KEY = 3'd3;
  localparam logic [2:0] S_SC_RD  = 3'd4;
  localparam logic [2:0] S_SC_CMP = 3'd5;
  localparam logic [2:0] S_DN_RD  = 3'd6;
  localparam logic [2:0] S_DN_WR  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       del_r, del_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    del_nxt   = del_r;
    valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          del_nxt  = (in_kind == KIND_DELETE);
          unique case (in_kind)
            KIND_INSERT: begin
              if (status.ins_ok) begin
                cmd.ptr_to_count = 1'b1;
                state_nxt = status.cnt_gt_inpos ? S_UP_RD : S_WR_KEY;
              end else begin
                cmd.res_set = 1'b1;
                cmd.res_idx = IDX_NONE;
                valid_nxt   = 1'b1;
              end
            end
            KIND_DELETE, KIND_SEARCH: begin
              if (status.cnt_zero) begin
                cmd.res_set = 1'b1;
                cmd.res_idx = IDX_NONE;
                valid_nxt   = 1'b1;
              end else begin
                cmd.ptr_to_zero = 1'b1;
                state_nxt = S_SC_RD;
              end
            end
            KIND_CLEAR: begin
              cmd.cnt_clr = 1'b1;
              cmd.res_set = 1'b1;
              cmd.res_ok  = 1'b1;
              cmd.res_idx = IDX_NONE;
              valid_nxt   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_UP_RD: begin
        cmd.rd_sel = RD_DEC;
        state_nxt  = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.ptr_dec = 1'b1;
        state_nxt   = status.ptr_dec_gt_pos ? S_UP_RD : S_WR_KEY;
      end
      S_WR_KEY: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_key  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.res_set = 1'b1;
        cmd.res_ok  = 1'b1;
        cmd.res_idx = IDX_POS;
        valid_nxt   = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SC_RD: begin
        cmd.rd_sel = RD_PTR;
        state_nxt  = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (status.match) begin
          if (del_r && status.scan_more) begin
            cmd.hit_save = 1'b1;
            state_nxt    = S_DN_RD;
          end else begin
            // search hit, or delete of the last entry: nothing to shift
            cmd.cnt_dec = del_r;
            cmd.res_set = 1'b1;
            cmd.res_ok  = 1'b1;
            cmd.res_idx = IDX_PTR;
            valid_nxt   = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else if (status.scan_more) begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SC_RD;
        end else begin
          cmd.res_set = 1'b1;
          cmd.res_idx = IDX_NONE;
          valid_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_DN_RD: begin
        cmd.rd_sel = RD_INC;
        state_nxt  = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (status.dn_more) begin
          state_nxt = S_DN_RD;
        end else begin
          cmd.cnt_dec = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b1;
          cmd.res_idx = IDX_HIT;
          valid_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      del_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      del_r   <= del_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

// File: src/sequential_list_engine_core.sv
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Ordered list of signed 32-bit keys with insert, delete, search and clear.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken on a clock edge where start is high and busy is low;
//   in_kind selects insert, delete, search or clear, in_key and in_position
//   carry the operands. Each command gives exactly one result: out_valid is
//   high for one cycle with out_ok, out_index (-1 on failure or clear) and
//   out_count (entries after the command). The receiver cannot stall; the
//   result is simply presented for that one cycle, and the next command may
//   be issued in that same cycle.
// Steps of each command, from the accepting edge to the result strobe:
//   clear, failed insert, delete/search on an empty list: result in the next cycle
//   insert at position p with n entries: move the n-p entries from p up, then write the key
//   search hitting index h: scan entries 0 to h; miss: scan all n entries
//   delete hitting index h: scan to h, then move the tail down one slot
//   Each scanned entry takes a read and a compare state, each moved entry a
//   read and a write state on the single read port of the entry RAM.
//   busy stays high until the strobe.
// Reset (synchronous, rst_n low) empties the list; entry contents are not
// cleared, only slots below the count are ever read.
// ----------------------------------------------------------------------------
module sequential_list_engine_core
  import slist_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic        [1:0]        in_kind,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic        [POS_W-1:0]  in_position,
  output logic                     out_valid,
  output logic                     out_ok,
  output logic signed [IDX_W-1:0]  out_index,
  output logic        [COUT_W-1:0] out_count
);

  slist_cmd_t    cmd;
  slist_status_t status;

  slist_ctrl u_slist_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  slist_datapath u_slist_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_key      (in_key),
    .in_position (in_position),
    .status      (status),
    .out_ok      (out_ok),
    .out_index   (out_index),
    .out_count   (out_count)
  );

endmodule

// File: src/slist_checker.sv
// ----------------------------------------------------------------------------
// slist_checker
// Port-level checks on the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module slist_checker
  import slist_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic        [1:0]        in_kind,
  input logic                     out_valid,
  input logic                     out_ok,
  input logic signed [IDX_W-1:0]  out_index,
  input logic        [COUT_W-1:0] out_count
);

  // failed commands report no index
  a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_index == '1)
    else $error("failed item reports an index");

  // a result only follows an accepted item or work in progress
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result strobe without an item");

  // the engine is free again when it shows a result
  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // clear answers in the next cycle with an empty list
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == KIND_CLEAR |=>
      out_valid && out_ok && out_count == '0 && out_index == '1)
    else $error("clear item gave a wrong result");

endmodule

bind sequential_list_engine_core slist_checker u_slist_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_kind   (in_kind),
  .out_valid (out_valid),
  .out_ok    (out_ok),
  .out_index (out_index),
  .out_count (out_count)
);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sequential_list_engine_core. A short table of
// directed commands covers the empty list, list ends, out-of-range positions,
// duplicates and clear. Random episodes then grow and shrink the list, fill it
// up and drain it again. Every result is checked against a local model of the
// list, and the sender pacing changes from phase to phase.
// ----------------------------------------------------------------------------
module testbench
  import slist_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int REPORT_MAX   = 10;
  localparam int N_DIRECTED   = 22;

  localparam logic [IDX_W-1:0] NO_SLOT = '1;
  localparam logic [KEY_W-1:0] MAX_KEY = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] MIN_KEY = 32'h8000_0000;
  localparam logic [KEY_W-1:0] NEG_ONE = 32'hffff_ffff;
  localparam logic [KEY_W-1:0] ALT_A   = 32'h5555_5555;
  localparam logic [KEY_W-1:0] ALT_B   = 32'haaaa_aaaa;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
  } list_op_t;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  index;
    logic [COUT_W-1:0] count;
  } list_result_t;

  typedef struct {
    list_op_t     op;
    logic         pinned;
    list_result_t want;
  } directed_row_t;

  typedef struct {
    list_op_t     op;
    list_result_t want;
  } awaited_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_kind = KIND_INSERT;
  logic [KEY_W-1:0]  in_key = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic              out_valid;
  logic              out_ok;
  logic [IDX_W-1:0]  out_index;
  logic [COUT_W-1:0] out_count;

  // list model and scoreboard
  logic [KEY_W-1:0] list_keys [CAPACITY];
  int               list_len = 0;
  awaited_t         awaited_results [$];
  int               sender_idle_pct = 0;
  int               fail_count = 0;
  int               checked_count = 0;
  int               cycle_count = 0;
  int               kind_count [4] = '{0, 0, 0, 0};
  int               kind_ok [4] = '{0, 0, 0, 0};
  int               full_rejects = 0;
  int               peak_len = 0;

  // ok, index, count are typed in only where they are obvious
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{KIND_SEARCH, 32'd0,   7'd0},   1'b1, '{1'b0, NO_SLOT, 7'd0}},
    '{'{KIND_DELETE, 32'd5,   7'd0},   1'b1, '{1'b0, NO_SLOT, 7'd0}},
    '{'{KIND_INSERT, 32'd9,   7'd1},   1'b1, '{1'b0, NO_SLOT, 7'd0}},
    '{'{KIND_INSERT, MAX_KEY, 7'd0},   1'b1, '{1'b1, 7'd0,    7'd1}},
    '{'{KIND_INSERT, MIN_KEY, 7'd1},   1'b1, '{1'b1, 7'd1,    7'd2}},
    '{'{KIND_INSERT, NEG_ONE, 7'd0},   1'b1, '{1'b1, 7'd0,    7'd3}},
    '{'{KIND_INSERT, 32'd0,   7'd127}, 1'b1, '{1'b0, NO_SLOT, 7'd3}},
    '{'{KIND_INSERT, 32'd0,   7'd4},   1'b1, '{1'b0, NO_SLOT, 7'd3}},
    '{'{KIND_INSERT, MIN_KEY, 7'd3},   1'b0, '0},
    '{'{KIND_SEARCH, MIN_KEY, 7'd0},   1'b0, '0},
    '{'{KIND_DELETE, MIN_KEY, 7'd0},   1'b0, '0},
    '{'{KIND_SEARCH, MIN_KEY, 7'd0},   1'b0, '0},
    '{'{KIND_SEARCH, 32'd12345, 7'd0}, 1'b0, '0},
    '{'{KIND_INSERT, ALT_A,   7'd2},   1'b0, '0},
    '{'{KIND_DELETE, NEG_ONE, 7'd0},   1'b0, '0},
    '{'{KIND_DELETE, MAX_KEY, 7'd0},   1'b0, '0},
    '{'{KIND_SEARCH, ALT_B,   7'd0},   1'b0, '0},
    '{'{KIND_CLEAR,  ALT_B,   7'd127}, 1'b1, '{1'b1, NO_SLOT, 7'd0}},
    '{'{KIND_SEARCH, ALT_A,   7'd0},   1'b1, '{1'b0, NO_SLOT, 7'd0}},
    '{'{KIND_DELETE, MIN_KEY, 7'd0},   1'b1, '{1'b0, NO_SLOT, 7'd0}},
    '{'{KIND_CLEAR,  32'd0,   7'd0},   1'b1, '{1'b1, NO_SLOT, 7'd0}},
    '{'{KIND_INSERT, ALT_B,   7'd0},   1'b1, '{1'b1, 7'd0,    7'd1}}
  };

  logic [KEY_W-1:0] key_pool [8] = '{32'd0, NEG_ONE, MAX_KEY, MIN_KEY,
                                     32'd1, 32'd7, ALT_A, ALT_B};

  sequential_list_engine_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_key      (in_key),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_ok      (out_ok),
    .out_index   (out_index),
    .out_count   (out_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // applies one command to the list model and returns what the block must report
  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t res;
    int           hit;
    int           i;
    res.ok = 1'b0;
    res.index = NO_SLOT;
    hit = -1;
    if (op.kind == KIND_DELETE || op.kind == KIND_SEARCH) begin
      for (i = list_len - 1; i >= 0; i--) begin
        if (list_keys[i] == op.key) hit = i;
      end
    end
    case (op.kind)
      KIND_INSERT: begin
        if (list_len < CAPACITY && int'(op.position) <= list_len) begin
          for (i = list_len; i > int'(op.position); i--) list_keys[i] = list_keys[i-1];
          list_keys[op.position] = op.key;
          list_len++;
          res.ok = 1'b1;
          res.index = IDX_W'(op.position);
        end
      end
      KIND_DELETE: begin
        if (hit >= 0) begin
          for (i = hit; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
          list_len--;
          res.ok = 1'b1;
          res.index = IDX_W'(hit);
        end
      end
      KIND_SEARCH: begin
        if (hit >= 0) begin
          res.ok = 1'b1;
          res.index = IDX_W'(hit);
        end
      end
      KIND_CLEAR: begin
        list_len = 0;
        res.ok = 1'b1;
      end
    endcase
    res.count = COUT_W'(list_len);
    return res;
  endfunction

  // mostly keys that hit: a small pool of corner values and keys already stored
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 40) return key_pool[$urandom_range(7, 0)];
    if (roll < 70 && list_len > 0) return list_keys[$urandom_range(list_len - 1, 0)];
    return $urandom;
  endfunction

  // mode 0 grows the list, mode 1 drains it, mode 2 mixes
  function automatic list_op_t pick_op(int mode);
    list_op_t op;
    int       roll;
    int       ins_w;
    int       del_w;
    int       clr_w;
    case (mode)
      0: begin
        ins_w = 72; del_w = 10; clr_w = 1;
      end
      1: begin
        ins_w = 15; del_w = 55; clr_w = 4;
      end
      default: begin
        ins_w = 40; del_w = 25; clr_w = 3;
      end
    endcase
    roll = $urandom_range(99, 0);
    if (roll < ins_w) op.kind = KIND_INSERT;
    else if (roll < ins_w + del_w) op.kind = KIND_DELETE;
    else if (roll < 100 - clr_w) op.kind = KIND_SEARCH;
    else op.kind = KIND_CLEAR;
    op.key = pick_key();
    roll = $urandom_range(99, 0);
    if (roll < 20) op.position = '0;
    else if (roll < 40) op.position = POS_W'(list_len);
    else if (roll < 85) op.position = POS_W'($urandom_range(list_len, 0));
    else op.position = POS_W'($urandom_range(127, 0));
    return op;
  endfunction

  // holds the item until it is taken, then records what it must produce
  task automatic drive_item(input list_op_t op, input logic pinned,
                            input list_result_t pinned_want);
    awaited_t entry;
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_kind     <= op.kind;
    in_key      <= op.key;
    in_position <= op.position;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (op.kind == KIND_INSERT && list_len == CAPACITY) full_rejects++;
    entry.op = op;
    entry.want = apply_list_op(op);
    kind_count[op.kind]++;
    if (entry.want.ok) kind_ok[op.kind]++;
    if (list_len > peak_len) peak_len = list_len;
    if (pinned) entry.want = pinned_want;
    awaited_results.push_back(entry);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    awaited_t     head;
    list_result_t got;
    if (rst_n && out_valid === 1'b1) begin
      got = '{out_ok, out_index, out_count};
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: ok=%0b index=%0d count=%0d",
                   got.ok, $signed(got.index), got.count);
      end else begin
        head = awaited_results.pop_front();
        checked_count++;
        if (got !== head.want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch on kind %0d key %0d pos %0d: expected ok=%0b index=%0d count=%0d, got ok=%0b index=%0d count=%0d",
                     head.op.kind, $signed(head.op.key), head.op.position,
                     head.want.ok, $signed(head.want.index), head.want.count,
                     got.ok, $signed(got.index), got.count);
        end
      end
    end
  end

  initial begin
    int ep_left;
    int mode;
    int n;
    ep_left = 0;
    mode = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 17;
    for (n = 0; n < N_DIRECTED; n++)
      drive_item(directed_rows[n].op, directed_rows[n].pinned, directed_rows[n].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) sender_idle_pct = 86;
      else if (n == 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
      if (ep_left == 0) begin
        mode = $urandom_range(2, 0);
        ep_left = $urandom_range(120, 20);
      end
      ep_left--;
      drive_item(pick_op(mode), 1'b0, '0);
    end
    start <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("inserts %0d (%0d placed, %0d into a full list), deletes %0d (%0d removed), searches %0d (%0d hits), clears %0d",
             kind_count[KIND_INSERT], kind_ok[KIND_INSERT], full_rejects,
             kind_count[KIND_DELETE], kind_ok[KIND_DELETE],
             kind_count[KIND_SEARCH], kind_ok[KIND_SEARCH], kind_count[KIND_CLEAR]);
    $display("longest list %0d of %0d, %0d results checked, %0d failures",
             peak_len, CAPACITY, checked_count, fail_count);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
